@@ sv/b64d_pkg.sv @@
package b64d_pkg;

  localparam int unsigned JOB_DEPTH = 2;

  localparam logic [5:0] IDX_UPPER = 6'd0;
  localparam logic [5:0] IDX_LOWER = 6'd26;
  localparam logic [5:0] IDX_DIGIT = 6'd52;
  localparam logic [5:0] IDX_PLUS  = 6'd62;
  localparam logic [5:0] IDX_SLASH = 6'd63;

  localparam logic [2:0] PAD_MAX = 3'd7;

  typedef enum logic [1:0] {
    STATUS_DATA    = 2'd0,
    STATUS_BAD     = 2'd1,
    STATUS_LEN_ERR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_BAD,
    JOB_LEN
  } job_kind_e;

  // one queue entry: all results caused by one input transaction
  typedef struct packed {
    job_kind_e   kind;
    logic [1:0]  nres;   // number of results, 1..3
    logic [23:0] word;
  } job_t;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] value;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r = '{bad: 1'b0, pad: 1'b0, value: 6'd0};
    if (c inside {[8'h41:8'h5A]}) begin
      r.value = 6'(c - 8'h41) + IDX_UPPER;
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.value = 6'(c - 8'h61) + IDX_LOWER;
    end else if (c inside {[8'h30:8'h39]}) begin
      r.value = 6'(c - 8'h30) + IDX_DIGIT;
    end else if (c == 8'h2B) begin
      r.value = IDX_PLUS;
    end else if (c == 8'h2F) begin
      r.value = IDX_SLASH;
    end else if (c == 8'h3D) begin
      r.pad = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ sv/b64d_front.sv @@
module b64d_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [7:0]       char_code_i,
  input  logic             is_final_i,
  output logic             job_push_o,
  output b64d_pkg::job_t   job_o
);

  logic [23:0] word_q, word_d;
  logic [1:0]  pos_q, pos_d;
  logic [2:0]  pad_q, pad_d;
  logic        err_q, err_d;

  b64d_pkg::char_class_t cls;
  logic [23:0] word_n;
  logic [1:0]  pos_n;
  logic [2:0]  pad_n;
  logic [1:0]  count;

  assign cls = b64d_pkg::classify(char_code_i);

  always_comb begin
    word_d     = word_q;
    pos_d      = pos_q;
    pad_d      = pad_q;
    err_d      = err_q;
    job_push_o = 1'b0;
    job_o      = '{kind: b64d_pkg::JOB_DATA, nres: 2'd1, word: 24'd0};
    word_n     = {word_q[17:0], cls.value};
    pos_n      = pos_q + 2'd1;
    pad_n      = (cls.pad && pad_q < b64d_pkg::PAD_MAX) ? pad_q + 3'd1 : pad_q;
    count      = (pad_n >= 3'd3) ? 2'd0 : 2'(3'd3 - pad_n);

    if (valid_i) begin
      if (err_q) begin
        // discarding until the final marker
        if (is_final_i) begin
          err_d  = 1'b0;
          word_d = '0;
          pos_d  = '0;
          pad_d  = '0;
        end
      end else if (cls.bad) begin
        job_push_o = 1'b1;
        job_o.kind = b64d_pkg::JOB_BAD;
        err_d      = ~is_final_i;
        word_d     = '0;
        pos_d      = '0;
        pad_d      = '0;
      end else begin
        word_d = word_n;
        pos_d  = pos_n;
        pad_d  = pad_n;
        if (pos_n == 2'd0) begin
          job_push_o = (count != 2'd0);
          job_o.word = word_n;
          job_o.nres = count;
          word_d     = '0;
          pad_d      = '0;
        end
        if (is_final_i) begin
          if (pos_n != 2'd0) begin
            job_push_o = 1'b1;
            job_o.kind = b64d_pkg::JOB_LEN;
            job_o.nres = 2'd1;
          end
          word_d = '0;
          pos_d  = '0;
          pad_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      pos_q  <= '0;
      pad_q  <= '0;
      err_q  <= 1'b0;
    end else begin
      word_q <= word_d;
      pos_q  <= pos_d;
      pad_q  <= pad_d;
      err_q  <= err_d;
    end
  end

endmodule

@@ sv/b64d_job_queue.sv @@
module b64d_job_queue #(
  parameter int unsigned Depth = b64d_pkg::JOB_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output b64d_pkg::job_t job_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  b64d_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == LastPtr) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = do_pop  ? ((rd_q == LastPtr) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("job queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (wr_q == rd_q))
    else $error("job queue empty with unequal pointers");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o)
    else $error("job queue left full without a pop");

endmodule

@@ sv/b64d_back.sv @@
module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_empty_i,
  input  b64d_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           out_valid_o,
  input  logic           out_pop_i,
  output logic [7:0]     data_byte_o,
  output logic [1:0]     status_o,
  output logic           run_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic [1:0] status_q, status_d;
  logic       end_q, end_d;
  logic       load, last;

  // output register takes a new result when empty or being drained
  assign load      = ~job_empty_i & (~vld_q | out_pop_i);
  assign last      = (idx_q == job_i.nres - 2'd1);
  assign job_pop_o = load & last;

  always_comb begin
    idx_d    = idx_q;
    vld_d    = vld_q & ~out_pop_i;
    byte_d   = byte_q;
    status_d = status_q;
    end_d    = end_q;
    if (load) begin
      vld_d  = 1'b1;
      end_d  = last;
      idx_d  = last ? 2'd0 : idx_q + 2'd1;
      byte_d = 8'd0;
      case (job_i.kind)
        b64d_pkg::JOB_DATA: begin
          status_d = b64d_pkg::STATUS_DATA;
          case (idx_q)
            2'd0:    byte_d = job_i.word[23:16];
            2'd1:    byte_d = job_i.word[15:8];
            default: byte_d = job_i.word[7:0];
          endcase
        end
        b64d_pkg::JOB_BAD: status_d = b64d_pkg::STATUS_BAD;
        default:           status_d = b64d_pkg::STATUS_LEN_ERR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    status_q <= status_d;
    end_q    <= end_d;
  end

  assign out_valid_o = vld_q;
  assign data_byte_o = byte_q;
  assign status_o    = status_q;
  assign run_end_o   = end_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_empty_i |-> (idx_q < job_i.nres))
    else $error("result index beyond job result count");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && status_q != b64d_pkg::STATUS_DATA) |-> end_q)
    else $error("error result not closing its transaction");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && status_q != b64d_pkg::STATUS_DATA) |-> (byte_q == 8'd0))
    else $error("error result carries nonzero byte");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_empty_i |-> (idx_q == 2'd0))
    else $error("result index left mid-job with no job");

endmodule

@@ sv/base64_stream_decoder.sv @@
// Channel   Direction  Handshake          Payload
// input     in         push / full        char_code_i, is_final_i
// result    out        empty / pop        data_byte_o, status_o, run_end_o
//
// One character is taken per cycle while full is low; the front decodes it and
// queues one job per transaction that yields results. The back emits one result
// per cycle from the job queue (Depth entries) through a single output register,
// so a complete group yields 0 to 3 results. Reset clears group state, queue and
// output register. full rises only when the job queue is full; a stalled pop
// holds the output register and backs up into the queue.
module base64_stream_decoder #(
  parameter int unsigned JobDepth = b64d_pkg::JOB_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  input  logic       is_final_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic [1:0] status_o,
  output logic       run_end_o
);

  b64d_pkg::job_t fr_job, q_job;
  logic fr_push, q_full, q_empty, q_pop, out_valid;

  assign full = q_full;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (push & ~q_full),
    .char_code_i (char_code_i),
    .is_final_i  (is_final_i),
    .job_push_o  (fr_push),
    .job_o       (fr_job)
  );

  b64d_job_queue #(
    .Depth (JobDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .job_i   (fr_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_job),
    .empty_o (q_empty)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (q_empty),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .data_byte_o (data_byte_o),
    .status_o    (status_o),
    .run_end_o   (run_end_o)
  );

  assign empty = ~out_valid;

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]         data_byte;
    b64d_pkg::status_e  status;
    logic               run_end;
  } result_t;

  // how a directed row is checked: by the decoder model, no result, or one typed error
  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_SILENT,
    ROW_ERR
  } row_kind_e;

  typedef struct packed {
    logic [7:0]         ch;
    logic               fin;
    row_kind_e          kind;
    b64d_pkg::status_e  st;
  } row_t;

  localparam int DIR_ROWS     = 24;
  localparam int RAND_ITEMS   = 320;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 30;
  localparam int DRAIN_CYCLES = 20;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_code_i = 8'h00;
  logic       is_final_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] data_byte_o;
  logic [1:0] status_o;
  logic       run_end_o;

  // decoder state mirror
  logic [23:0] grp_word = '0;
  logic [1:0]  grp_pos = '0;
  logic [2:0]  pad_cnt = '0;
  logic        err_seen = 1'b0;

  result_t decoded_q[$];
  int      errors = 0;
  int      live_items = 0;
  int      n_popped = 0;
  bit      tx_burst = 1'b0;
  bit      rx_burst = 1'b0;
  bit      held = 1'b0;

  row_t dir_tab [DIR_ROWS] = '{
    '{8'hFF, 1'b0, ROW_ERR,    b64d_pkg::STATUS_BAD},     // top code, sets discard
    '{"A",   1'b0, ROW_SILENT, b64d_pkg::STATUS_DATA},    // discarded
    '{8'h00, 1'b1, ROW_SILENT, b64d_pkg::STATUS_DATA},    // final ends discard
    '{"/",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"+",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"9",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"z",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"Q",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"Q",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"=",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"=",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"A",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},    // three pads: no bytes
    '{"=",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"=",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"=",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"A",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"B",   1'b1, ROW_ERR,    b64d_pkg::STATUS_LEN_ERR}, // final inside a group
    '{8'h80, 1'b1, ROW_ERR,    b64d_pkg::STATUS_BAD},     // high half, final: no discard
    '{"a",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"*",   1'b1, ROW_ERR,    b64d_pkg::STATUS_BAD},     // bad char wins over length error
    '{"Q",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"U",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"J",   1'b0, ROW_MODEL,  b64d_pkg::STATUS_DATA},
    '{"=",   1'b1, ROW_MODEL,  b64d_pkg::STATUS_DATA}
  };

  base64_stream_decoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .char_code_i(char_code_i),
    .is_final_i (is_final_i),
    .empty      (empty),
    .pop        (pop),
    .data_byte_o(data_byte_o),
    .status_o   (status_o),
    .run_end_o  (run_end_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] sextet_char(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  // advances the mirror by one character; queues its results when keep is set
  function automatic void decode_char(input logic [7:0] ch, input logic fin, input bit keep);
    result_t    res[$];
    logic [5:0] val;
    bit         pad_ch;
    bit         bad_ch;
    int         nbytes;
    int         k;
    if (err_seen) begin
      if (fin) begin
        err_seen = 1'b0;
        grp_word = '0;
        grp_pos  = '0;
        pad_cnt  = '0;
      end
      return;
    end
    val    = '0;
    pad_ch = 1'b0;
    bad_ch = 1'b0;
    if (ch >= "A" && ch <= "Z") val = 6'(ch - "A");
    else if (ch >= "a" && ch <= "z") val = 6'(ch - "a" + 26);
    else if (ch >= "0" && ch <= "9") val = 6'(ch - "0" + 52);
    else if (ch == "+") val = 6'd62;
    else if (ch == "/") val = 6'd63;
    else if (ch == "=") pad_ch = 1'b1;
    else bad_ch = 1'b1;

    if (bad_ch) begin
      res.push_back('{8'h00, b64d_pkg::STATUS_BAD, 1'b1});
      grp_word = '0;
      grp_pos  = '0;
      pad_cnt  = '0;
      if (!fin) err_seen = 1'b1;
    end else begin
      grp_word = {grp_word[17:0], val};
      if (pad_ch && pad_cnt != 3'd7) pad_cnt++;
      grp_pos++;
      if (grp_pos == 2'd0) begin
        nbytes = (pad_cnt >= 3) ? 0 : 3 - pad_cnt;
        for (k = 0; k < nbytes; k++) begin
          res.push_back('{grp_word[23 - 8*k -: 8], b64d_pkg::STATUS_DATA, 1'b0});
        end
        grp_word = '0;
        pad_cnt  = '0;
      end
      if (fin) begin
        if (grp_pos != 2'd0) res.push_back('{8'h00, b64d_pkg::STATUS_LEN_ERR, 1'b0});
        grp_word = '0;
        grp_pos  = '0;
        pad_cnt  = '0;
      end
      if (res.size() > 0) res[res.size()-1].run_end = 1'b1;
    end
    if (keep) begin
      foreach (res[j]) decoded_q.push_back(res[j]);
    end
  endfunction

  // one input transaction; returns at the edge where it was taken
  task automatic send_char(input logic [7:0] ch, input logic fin, input bit keep);
    int   gap;
    logic stalled;
    if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    char_code_i <= ch;
    is_final_i  <= fin;
    do begin
      @(negedge clk_i);
      stalled = full;
      @(posedge clk_i);
    end while (stalled);
    if (!err_seen) live_items++;
    decode_char(ch, fin, keep);
  endtask

  initial begin : stimulus
    logic [7:0] seq_ch[$];
    int         kind;
    int         ngrp;
    int         npad;
    int         i;
    logic       last_fin;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      send_char(dir_tab[r].ch, dir_tab[r].fin, dir_tab[r].kind == ROW_MODEL);
      if (dir_tab[r].kind == ROW_ERR) decoded_q.push_back('{8'h00, dir_tab[r].st, 1'b1});
    end

    while (live_items < DIR_ROWS + RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      seq_ch.delete();
      if (kind <= 7) begin
        // well-formed string; kind 7 gets broken afterwards
        ngrp = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 2);
        for (i = 0; i < ngrp * 4; i++) seq_ch.push_back(sextet_char($urandom_range(0, 63)));
        npad = $urandom_range(0, 2);
        for (i = 0; i < npad; i++) seq_ch[seq_ch.size() - 1 - i] = "=";
        if (kind == 7) begin
          if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 3)) void'(seq_ch.pop_back());
          end else begin
            seq_ch[$urandom_range(0, seq_ch.size() - 1)] = 8'($urandom_range(0, 255));
          end
        end
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 6)) seq_ch.push_back(8'($urandom_range(0, 255)));
      end else begin
        // heavy padding mix
        for (i = 0; i < 4; i++) begin
          seq_ch.push_back($urandom_range(0, 1) ? "=" : sextet_char($urandom_range(0, 63)));
        end
      end
      last_fin = (kind <= 7) ? 1'b1 : 1'($urandom_range(0, 1));
      for (i = 0; i < seq_ch.size(); i++) begin
        send_char(seq_ch[i], last_fin && (i == seq_ch.size() - 1), 1'b1);
      end
    end
    push <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int         wait_cyc;
    logic       em;
    logic [7:0] b;
    logic [1:0] st;
    logic       re;
    result_t    want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
      wait_cyc = rx_burst ? 0 : $urandom_range(0, 19);
      // one long hold-off so the job queue fills and full backs up the input
      if (!held && n_popped >= HOLD_AFTER) begin
        held     = 1'b1;
        wait_cyc = HOLD_CYCLES;
      end
      if (wait_cyc > 0) begin
        pop <= 1'b0;
        repeat (wait_cyc) @(posedge clk_i);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk_i);
        em = empty;
        b  = data_byte_o;
        st = status_o;
        re = run_end_o;
        @(posedge clk_i);
      end while (em);
      n_popped++;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: data_byte %h status %0d run_end %b", b, st, re);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (b !== want.data_byte) begin
          $error("data_byte: expected %h, actual %h", want.data_byte, b);
          errors++;
        end
        if (st !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, st);
          errors++;
        end
        if (re !== want.run_end) begin
          $error("run_end: expected %b, actual %b", want.run_end, re);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #(2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
